FILE: src/small_matrix_multiply_macros.svh
// assertion macros for the small matrix multiply checker
// needs clk and rst_n in the scope that uses them
`ifndef SMALL_MATRIX_MULTIPLY_MACROS_SVH
`define SMALL_MATRIX_MULTIPLY_MACROS_SVH

// same-cycle implication, checked outside reset
`define SMM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/smm_pkg.sv
// shared types and constants for the small matrix multiply block
// no dependencies
`default_nettype none

package smm_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 2;
    localparam int DIM_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * DATA_W;
    // room for the sum of up to seven full-width products
    localparam int ACC_W     = PROD_W + DIM_W;

    typedef enum logic [1:0] {
        OP_LOAD_LEFT  = 2'd0,
        OP_LOAD_RIGHT = 2'd1,
        OP_COMPUTE    = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_COLS_B    = 2'd2
    } cfg_index_t;

    // command from controller to datapath
    typedef struct packed {
        logic             wr_left;
        logic             wr_right;
        logic             issue;
        logic             first;
        logic             last_k;
        logic             last_elem;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] k;
    } smm_cmd_t;

endpackage

`default_nettype wire

FILE: src/smm_ctrl.sv
// controller: dimension registers, request acceptance and the i/j/k sequencer
// depends on smm_pkg
`default_nettype none

module smm_ctrl
    import smm_pkg::*;
#(
    parameter int MAX_DIM = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [1:0]           opcode,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    output logic                      cfg_ready,
    output logic                      busy,
    input  wire logic                 pipe_busy,
    output smm_cmd_t                  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [DIM_W-1:0] nr_reg, nc_reg, nk_reg;
    logic [DIM_W-1:0] nr_next, nc_next, nk_next;
    logic [DIM_W-1:0] i_reg, j_reg, k_reg;
    logic [DIM_W-1:0] i_next, j_next, k_next;
    logic             accept;
    logic             k_end, j_end, i_end;

    // zero counts as one, anything past the store size is clipped
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(d) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    // dimension registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_W'(3);
            inner_dim_reg <= DIM_W'(3);
            cols_b_reg    <= DIM_W'(3);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign busy   = (state_reg == ST_RUN) || pipe_busy;
    assign accept = start && !busy;

    assign k_end = (k_reg == nk_reg - DIM_W'(1));
    assign j_end = (j_reg == nc_reg - DIM_W'(1));
    assign i_end = (i_reg == nr_reg - DIM_W'(1));

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        nr_next    = nr_reg;
        nc_next    = nc_reg;
        nk_next    = nk_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == OP_COMPUTE)
                begin
                    state_next = ST_RUN;
                    nr_next    = eff_dim(rows_a_reg);
                    nc_next    = eff_dim(cols_b_reg);
                    nk_next    = eff_dim(inner_dim_reg);
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (!k_end)
                begin
                    k_next = k_reg + DIM_W'(1);
                end
                else
                begin
                    k_next = '0;
                    if (!j_end)
                    begin
                        j_next = j_reg + DIM_W'(1);
                    end
                    else
                    begin
                        j_next = '0;
                        if (!i_end)
                        begin
                            i_next = i_reg + DIM_W'(1);
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nr_reg    <= DIM_W'(1);
            nc_reg    <= DIM_W'(1);
            nk_reg    <= DIM_W'(1);
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            nr_reg    <= nr_next;
            nc_reg    <= nc_next;
            nk_reg    <= nk_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // command to the datapath
    always_comb
    begin
        cmd           = '0;
        cmd.wr_left   = accept && (opcode == OP_LOAD_LEFT);
        cmd.wr_right  = accept && (opcode == OP_LOAD_RIGHT);
        cmd.issue     = (state_reg == ST_RUN);
        cmd.first     = (k_reg == '0);
        cmd.last_k    = k_end;
        cmd.last_elem = k_end && j_end && i_end;
        cmd.row       = i_reg;
        cmd.col       = j_reg;
        cmd.k         = k_reg;
    end

endmodule

`default_nettype wire

FILE: src/smm_datapath.sv
// datapath: operand stores, multiplier, accumulator and output register
// depends on smm_pkg
`default_nettype none

module smm_datapath
    import smm_pkg::*;
#(
    parameter int MAX_DIM = 4
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire smm_cmd_t                 cmd,
    input  wire logic [IDX_W-1:0]         row_index,
    input  wire logic [IDX_W-1:0]         col_index,
    input  wire logic signed [DATA_W-1:0] element_value,
    output logic                          pipe_busy,
    output logic                          out_valid,
    output logic [IDX_W-1:0]              out_row,
    output logic [IDX_W-1:0]              out_col,
    output logic signed [DATA_W-1:0]      out_value,
    output logic                          saturated,
    output logic                          last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HI_LSB = FRAC_BITS + DATA_W - 1;

    logic [DATA_W-1:0]        left_mem  [DEPTH];
    logic [DATA_W-1:0]        right_mem [DEPTH];

    logic                     wr_in_range;
    logic [ADDR_W-1:0]        wr_addr, left_rd_addr, right_rd_addr;

    logic signed [DATA_W-1:0] a_rd_reg, b_rd_reg;
    logic                     s1_valid_reg, s1_first_reg, s1_last_k_reg, s1_last_elem_reg;
    logic [DIM_W-1:0]         s1_row_reg, s1_col_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     s2_valid_reg, s2_first_reg, s2_last_k_reg, s2_last_elem_reg;
    logic [DIM_W-1:0]         s2_row_reg, s2_col_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic                     done_reg, done_last_reg;
    logic [DIM_W-1:0]         done_row_reg, done_col_reg;

    logic [ACC_W-HI_LSB-1:0]  acc_hi;
    logic                     acc_fits;
    logic [DATA_W-1:0]        sat_value;

    logic                     out_valid_reg, out_sat_reg, out_last_reg;
    logic [DIM_W-1:0]         out_row_reg, out_col_reg;
    logic [DATA_W-1:0]        out_value_reg;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // store addressing
    assign wr_in_range   = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
    assign wr_addr       = addr_of(DIM_W'(row_index), DIM_W'(col_index));
    assign left_rd_addr  = addr_of(cmd.row, cmd.k);
    assign right_rd_addr = addr_of(cmd.k, cmd.col);

    // operand stores, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.wr_left && wr_in_range)
        begin
            left_mem[wr_addr] <= element_value;
        end
        if (cmd.wr_right && wr_in_range)
        begin
            right_mem[wr_addr] <= element_value;
        end
        if (cmd.issue)
        begin
            a_rd_reg <= left_mem[left_rd_addr];
            b_rd_reg <= right_mem[right_rd_addr];
        end
    end

    // pipeline control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            done_reg      <= s2_valid_reg && s2_last_k_reg;
            out_valid_reg <= done_reg;
        end
    end

    // tags travelling with the operands, multiply, accumulate
    always_ff @(posedge clk)
    begin
        s1_first_reg     <= cmd.first;
        s1_last_k_reg    <= cmd.last_k;
        s1_last_elem_reg <= cmd.last_elem;
        s1_row_reg       <= cmd.row;
        s1_col_reg       <= cmd.col;

        prod_reg         <= a_rd_reg * b_rd_reg;
        s2_first_reg     <= s1_first_reg;
        s2_last_k_reg    <= s1_last_k_reg;
        s2_last_elem_reg <= s1_last_elem_reg;
        s2_row_reg       <= s1_row_reg;
        s2_col_reg       <= s1_col_reg;

        if (s2_valid_reg)
        begin
            if (s2_first_reg)
            begin
                acc_reg <= ACC_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            done_row_reg  <= s2_row_reg;
            done_col_reg  <= s2_col_reg;
            done_last_reg <= s2_last_elem_reg;
        end
    end

    // drop the fraction and clip to 32 bits
    assign acc_hi    = acc_reg[ACC_W-1:HI_LSB];
    assign acc_fits  = (&acc_hi) || !(|acc_hi);
    assign sat_value = acc_fits ? acc_reg[HI_LSB:FRAC_BITS]
                     : (acc_reg[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}});

    // output register
    always_ff @(posedge clk)
    begin
        if (done_reg)
        begin
            out_value_reg <= sat_value;
            out_sat_reg   <= !acc_fits;
            out_row_reg   <= done_row_reg;
            out_col_reg   <= done_col_reg;
            out_last_reg  <= done_last_reg;
        end
    end

    assign pipe_busy = s1_valid_reg || s2_valid_reg || done_reg;
    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg[IDX_W-1:0];
    assign out_col   = out_col_reg[IDX_W-1:0];
    assign out_value = out_value_reg;
    assign saturated = out_sat_reg;
    // final mark only shows alongside the strobe
    assign last      = out_last_reg && out_valid_reg;

endmodule

`default_nettype wire

FILE: src/small_matrix_multiply.sv
// Fixed-point (signed Q16.16) product of a left matrix (rows_a x inner_dim) and a right
// matrix (inner_dim x cols_b), each dimension at most MAX_DIM. A request is taken when
// start is high and busy is low. A load request writes one element; the block is ready
// again in the next cycle. A compute request holds busy while it runs: one
// multiply-accumulate unit takes one product per cycle, with a four-stage path (store
// read, multiply, accumulate, output register). Each result element appears on the result
// ports for exactly one cycle with out_valid high, in row-major order, last marking the
// final one; the receiver cannot stall and must take each result as it comes. The final
// result appears in the same cycle that busy drops. Stores are not cleared by reset;
// elements must be loaded before use.
// Depends on smm_pkg, smm_ctrl and smm_datapath.
`default_nettype none

module small_matrix_multiply
    import smm_pkg::*;
#(
    parameter int MAX_DIM = 4
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               opcode,
    input  wire logic [IDX_W-1:0]         row_index,
    input  wire logic [IDX_W-1:0]         col_index,
    input  wire logic signed [DATA_W-1:0] element_value,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [DIM_W-1:0]         cfg_data,
    output logic                          out_valid,
    output logic [IDX_W-1:0]              out_row,
    output logic [IDX_W-1:0]              out_col,
    output logic signed [DATA_W-1:0]      out_value,
    output logic                          saturated,
    output logic                          last
);

    smm_cmd_t cmd;
    logic     pipe_busy;

    // sequencer and dimension registers
    smm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .busy      (busy),
        .pipe_busy (pipe_busy),
        .cmd       (cmd)
    );

    // stores and multiply-accumulate path
    smm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .pipe_busy     (pipe_busy),
        .out_valid     (out_valid),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_value     (out_value),
        .saturated     (saturated),
        .last          (last)
    );

endmodule

`default_nettype wire

FILE: src/smm_checker.sv
// port-level checks on the small matrix multiply, bound to the top level
// depends on smm_pkg and small_matrix_multiply_macros.svh
`default_nettype none

`include "small_matrix_multiply_macros.svh"

module smm_checker
    import smm_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] opcode,
    input wire logic       out_valid,
    input wire logic       last
);

    // a compute request keeps the block busy in the following cycle
    `SMM_ASSERT_NEXT(a_compute_busy, start && !busy && opcode == OP_COMPUTE, busy, "compute request did not raise busy")

    // every result comes out of a running computation
    `SMM_ASSERT_NOW(a_result_from_run, out_valid, $past(busy), "result without a computation in flight")

    // more results follow a non-final one, so the block stays busy
    `SMM_ASSERT_NOW(a_busy_until_last, out_valid && !last, busy, "busy dropped before the final result")

    // the final mark only rides on a result
    `SMM_ASSERT_NOW(a_last_qualified, last, out_valid, "last seen without a result")

endmodule

bind small_matrix_multiply smm_checker u_smm_checker (.*);

`default_nettype wire

FILE: dv/tb_small_matrix_multiply.sv
// self-checking testbench for small_matrix_multiply: directed table, then random load and
// compute requests over several dimension settings, results checked against a local model
// depends on smm_pkg and the small_matrix_multiply rtl
module tb_small_matrix_multiply;
    import smm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM_MAX       = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_PER_SET = 12;
    localparam int DRAIN_CYCLES  = 8;

    // codes the package does not name
    localparam logic [1:0]           OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              sat;
        logic              last;
    } product_elem_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              typed;
        logic [DATA_W-1:0] want_value;
        logic              want_sat;
    } directed_step_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               opcode;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DIM_W-1:0]         cfg_data;
    logic                     out_valid;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                     saturated;
    logic                     last;

    // local copy of the block state
    logic [DIM_W-1:0]         dim_rows;
    logic [DIM_W-1:0]         dim_inner;
    logic [DIM_W-1:0]         dim_cols;
    logic signed [DATA_W-1:0] left_model [DIM_MAX*DIM_MAX];
    logic signed [DATA_W-1:0] right_model [DIM_MAX*DIM_MAX];
    bit                       left_loaded [DIM_MAX*DIM_MAX];
    bit                       right_loaded [DIM_MAX*DIM_MAX];

    product_elem_t  pending_products [$];
    directed_step_t directed_steps [$];
    product_elem_t  head;

    int error_count;
    int requests_taken;
    int computes_taken;
    int results_seen;
    int settings_used;
    int cycle_count;
    int idle_pct;

    small_matrix_multiply #(
        .MAX_DIM(DIM_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .row_index    (row_index),
        .col_index    (col_index),
        .element_value(element_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_value    (out_value),
        .saturated    (saturated),
        .last         (last)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // zero counts as one, anything above the grid is clipped to it
    function automatic int dim_in_use(input logic [DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > DIM_MAX)
            return DIM_MAX;
        return d;
    endfunction

    // mix of extremes, full-range words and small signed values
    function automatic logic [DATA_W-1:0] rand_element();
        logic [DATA_W-1:0] mag;
        mag = $urandom_range(0, 32'h0003_FFFF);
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return ($urandom_range(0, 1) != 0) ? -mag : mag;
        endcase
    endfunction

    // full-width sum of products, floor shift, clip to 32 bits
    task automatic predict_product;
        int nr, nk, nc, i, j, k;
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  shifted;
        logic signed [ACC_W-1:0]  hi_lim;
        logic signed [ACC_W-1:0]  lo_lim;
        logic signed [PROD_W-1:0] term;
        product_elem_t            e;
        nr = dim_in_use(dim_rows);
        nk = dim_in_use(dim_inner);
        nc = dim_in_use(dim_cols);
        hi_lim = ACC_W'(32'sh7FFF_FFFF);
        lo_lim = ACC_W'(32'sh8000_0000);
        for (i = 0; i < nr; i++)
        begin
            for (j = 0; j < nc; j++)
            begin
                acc = '0;
                for (k = 0; k < nk; k++)
                begin
                    term = left_model[i*DIM_MAX+k] * right_model[k*DIM_MAX+j];
                    acc  = acc + ACC_W'(term);
                end
                shifted = acc >>> FRAC_BITS;
                e.row   = i[IDX_W-1:0];
                e.col   = j[IDX_W-1:0];
                e.sat   = 1'b1;
                if (shifted > hi_lim)
                    e.value = 32'h7FFF_FFFF;
                else if (shifted < lo_lim)
                    e.value = 32'h8000_0000;
                else
                begin
                    e.value = shifted[DATA_W-1:0];
                    e.sat   = 1'b0;
                end
                e.last = (i == nr - 1) && (j == nc - 1);
                pending_products.push_back(e);
            end
        end
    endtask

    // present one request, hold it until taken, then update the local state
    task automatic issue_request(input logic [1:0] op, input logic [IDX_W-1:0] r,
                                 input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v,
                                 input logic typed, input logic [DATA_W-1:0] want_v,
                                 input logic want_s);
        int            gap;
        product_elem_t e;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start         <= 1'b1;
        opcode        <= op;
        row_index     <= r;
        col_index     <= c;
        element_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_taken++;
        case (op)
            OP_LOAD_LEFT:
            begin
                left_model[r*DIM_MAX+c]  = v;
                left_loaded[r*DIM_MAX+c] = 1'b1;
            end
            OP_LOAD_RIGHT:
            begin
                right_model[r*DIM_MAX+c]  = v;
                right_loaded[r*DIM_MAX+c] = 1'b1;
            end
            OP_COMPUTE:
            begin
                computes_taken++;
                if (typed)
                begin
                    e.row   = '0;
                    e.col   = '0;
                    e.value = want_v;
                    e.sat   = want_s;
                    e.last  = 1'b1;
                    pending_products.push_back(e);
                end
                else
                    predict_product();
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ROWS_A:    dim_rows  = d;
            CFG_INNER_DIM: dim_inner = d;
            CFG_COLS_B:    dim_cols  = d;
            default: ;
        endcase
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ki,
                            input logic [DIM_W-1:0] cb);
        write_reg(CFG_ROWS_A, ra);
        write_reg(CFG_INNER_DIM, ki);
        write_reg(CFG_COLS_B, cb);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // stop sending and wait until every result is in and the block is quiet
    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (pending_products.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_step(input logic [1:0] op, input logic [IDX_W-1:0] r,
                            input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v,
                            input logic typed, input logic [DATA_W-1:0] want_v,
                            input logic want_s);
        directed_step_t s;
        s.op         = op;
        s.row        = r;
        s.col        = c;
        s.value      = v;
        s.typed      = typed;
        s.want_value = want_v;
        s.want_sat   = want_s;
        directed_steps.push_back(s);
    endtask

    // result checker: every strobe must match the oldest pending element
    always @(posedge clk)
    begin
        if (rst_n && out_valid)
        begin
            if (pending_products.size() == 0)
                note_mismatch($sformatf("result (%0d,%0d) %h with nothing pending",
                                        out_row, out_col, out_value));
            else
            begin
                head = pending_products.pop_front();
                results_seen++;
                if (out_row !== head.row)
                    note_mismatch($sformatf("out_row %0d, want %0d", out_row, head.row));
                if (out_col !== head.col)
                    note_mismatch($sformatf("out_col %0d, want %0d", out_col, head.col));
                if (out_value !== head.value)
                    note_mismatch($sformatf("(%0d,%0d) out_value %h, want %h",
                                            head.row, head.col, out_value, head.value));
                if (saturated !== head.sat)
                    note_mismatch($sformatf("(%0d,%0d) saturated %b, want %b",
                                            head.row, head.col, saturated, head.sat));
                if (last !== head.last)
                    note_mismatch($sformatf("(%0d,%0d) last %b, want %b",
                                            head.row, head.col, last, head.last));
            end
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run limit of %0d cycles reached", CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // stimulus
    initial
    begin
        int     phase, phase_items, pick, nr, nk, nc, i, j, k;
        bit     refresh;
        logic [1:0] op;

        rst_n          = 1'b0;
        start          = 1'b0;
        opcode         = OP_LOAD_LEFT;
        row_index      = '0;
        col_index      = '0;
        element_value  = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_ROWS_A;
        cfg_data       = '0;
        dim_rows       = 3'd3;
        dim_inner      = 3'd3;
        dim_cols       = 3'd3;
        error_count    = 0;
        requests_taken = 0;
        computes_taken = 0;
        results_seen   = 0;
        settings_used  = 0;
        idle_pct       = 0;
        for (i = 0; i < DIM_MAX * DIM_MAX; i++)
        begin
            left_model[i]   = '0;
            right_model[i]  = '0;
            left_loaded[i]  = 1'b0;
            right_loaded[i] = 1'b0;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part on a 1x1x1 product: zero dimensions count as one
        write_reg(CFG_UNUSED, 3'b101);
        set_dims(3'd0, 3'd1, 3'd0);
        add_step(OP_LOAD_LEFT,  2'd0, 2'd0, 32'h7FFF_FFFF, 1'b0, '0, 1'b0);
        add_step(OP_LOAD_RIGHT, 2'd0, 2'd0, 32'h7FFF_FFFF, 1'b0, '0, 1'b0);
        add_step(OP_COMPUTE,    2'd0, 2'd0, 32'h0,         1'b1, 32'h7FFF_FFFF, 1'b1);
        add_step(OP_LOAD_LEFT,  2'd0, 2'd0, 32'h8000_0000, 1'b0, '0, 1'b0);
        add_step(OP_LOAD_RIGHT, 2'd0, 2'd0, 32'h8000_0000, 1'b0, '0, 1'b0);
        add_step(OP_COMPUTE,    2'd3, 2'd3, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1);
        add_step(OP_LOAD_RIGHT, 2'd0, 2'd0, 32'h7FFF_FFFF, 1'b0, '0, 1'b0);
        add_step(OP_COMPUTE,    2'd0, 2'd0, 32'h0,         1'b1, 32'h8000_0000, 1'b1);
        add_step(OP_LOAD_LEFT,  2'd0, 2'd0, 32'h0001_0000, 1'b0, '0, 1'b0);
        add_step(OP_LOAD_RIGHT, 2'd0, 2'd0, 32'h0001_0000, 1'b0, '0, 1'b0);
        add_step(OP_COMPUTE,    2'd0, 2'd0, 32'h0,         1'b1, 32'h0001_0000, 1'b0);
        // one lsb below zero times one lsb rounds down to minus one lsb
        add_step(OP_LOAD_LEFT,  2'd0, 2'd0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
        add_step(OP_LOAD_RIGHT, 2'd0, 2'd0, 32'h0000_0001, 1'b0, '0, 1'b0);
        add_step(OP_COMPUTE,    2'd0, 2'd0, 32'h0,         1'b1, 32'hFFFF_FFFF, 1'b0);
        // unused opcode is ignored
        add_step(OP_UNUSED,     2'd3, 2'd3, 32'hA5A5_A5A5, 1'b0, '0, 1'b0);
        add_step(OP_LOAD_LEFT,  2'd3, 2'd3, 32'h1234_5678, 1'b0, '0, 1'b0);
        add_step(OP_LOAD_RIGHT, 2'd3, 2'd3, 32'hFEDC_BA98, 1'b0, '0, 1'b0);
        add_step(OP_LOAD_LEFT,  2'd0, 2'd0, 32'h0000_8000, 1'b0, '0, 1'b0);
        add_step(OP_LOAD_RIGHT, 2'd0, 2'd0, 32'hFFFF_0000, 1'b0, '0, 1'b0);
        add_step(OP_COMPUTE,    2'd0, 2'd0, 32'h0,         1'b1, 32'hFFFF_8000, 1'b0);
        // product below one lsb truncates to zero
        add_step(OP_LOAD_LEFT,  2'd0, 2'd0, 32'h0000_0001, 1'b0, '0, 1'b0);
        add_step(OP_LOAD_RIGHT, 2'd0, 2'd0, 32'h0000_0001, 1'b0, '0, 1'b0);
        add_step(OP_COMPUTE,    2'd0, 2'd0, 32'h0,         1'b1, 32'h0,         1'b0);
        foreach (directed_steps[s])
            issue_request(directed_steps[s].op, directed_steps[s].row, directed_steps[s].col,
                          directed_steps[s].value, directed_steps[s].typed,
                          directed_steps[s].want_value, directed_steps[s].want_sat);
        drain();

        // random part over several dimension settings
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_dims(3'd7, 3'd7, 3'd7);
                1: set_dims(3'd3, 3'd2, 3'd4);
                2: set_dims(3'd4, 3'd4, 3'd4);
                3: set_dims(3'd1, 3'd7, 3'd2);
                default: set_dims(DIM_W'($urandom_range(0, 7)), DIM_W'($urandom_range(0, 7)),
                                  DIM_W'($urandom_range(0, 7)));
            endcase
            idle_pct = (phase < 2) ? 20 : (phase < 4) ? 57 : 0;
            nr = dim_in_use(dim_rows);
            nk = dim_in_use(dim_inner);
            nc = dim_in_use(dim_cols);
            phase_items = 0;
            while (phase_items < ITEMS_PER_SET)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    issue_request(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom,
                                  1'b0, '0, 1'b0);
                    phase_items++;
                end
                else if (pick < 36)
                begin
                    // operands for the product, reloaded whole now and then
                    refresh = (pick < 16);
                    for (i = 0; i < nr; i++)
                        for (k = 0; k < nk; k++)
                            if (refresh || !left_loaded[i*DIM_MAX+k])
                            begin
                                issue_request(OP_LOAD_LEFT, IDX_W'(i), IDX_W'(k),
                                              rand_element(), 1'b0, '0, 1'b0);
                                phase_items++;
                            end
                    for (k = 0; k < nk; k++)
                        for (j = 0; j < nc; j++)
                            if (refresh || !right_loaded[k*DIM_MAX+j])
                            begin
                                issue_request(OP_LOAD_RIGHT, IDX_W'(k), IDX_W'(j),
                                              rand_element(), 1'b0, '0, 1'b0);
                                phase_items++;
                            end
                    issue_request(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom,
                                  1'b0, '0, 1'b0);
                    phase_items++;
                end
                else
                begin
                    op = (pick < 68) ? OP_LOAD_LEFT : OP_LOAD_RIGHT;
                    issue_request(op, IDX_W'($urandom), IDX_W'($urandom), rand_element(),
                                  1'b0, '0, 1'b0);
                    phase_items++;
                end
            end
            // hold off until the block has nothing left to deliver
            drain();
        end

        $display("covered %0d requests with %0d products, %0d result elements checked",
                 requests_taken, computes_taken, results_seen);
        $display("over %0d dimension settings, %0d mismatches", settings_used, error_count);
        if (error_count == 0 && pending_products.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
